FILE: rtl/mpbp_pkg.sv
// ----------------------------------------------------------------------------
// MQTT PUBLISH body parser package
// Shared types and constants for the PUBLISH body parser.
// ----------------------------------------------------------------------------
package mpbp_pkg;

   localparam int unsigned LenWidth   = 28;
   localparam int unsigned TopicWidth = 16;

   localparam logic [7:0] CharDollar = 8'h24;
   localparam logic [7:0] CharHash   = 8'h23;
   localparam logic [7:0] CharPlus   = 8'h2B;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_TLEN_HI = 3'd1,
      PH_TLEN_LO = 3'd2,
      PH_TOPIC   = 3'd3,
      PH_PID_HI  = 3'd4,
      PH_PID_LO  = 3'd5,
      PH_PAYLOAD = 3'd6,
      PH_DISCARD = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      ROLE_TLEN    = 3'd0,
      ROLE_TOPIC   = 3'd1,
      ROLE_PID     = 3'd2,
      ROLE_PAYLOAD = 3'd3,
      ROLE_DISCARD = 3'd4
   } role_type;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_QOS0_DUP = 3'd1,
      ERR_QOS3     = 3'd2,
      ERR_EMPTY    = 3'd3,
      ERR_DOLLAR   = 3'd4,
      ERR_WILDCARD = 3'd5,
      ERR_OVERRUN  = 3'd6
   } error_type;

   typedef struct packed {
      logic [7:0]          data_byte;
      logic                first;
      logic [3:0]          header_flags;
      logic [LenWidth-1:0] remaining_length;
   } req_item_type;

   typedef struct packed {
      logic [7:0] byte_value;
      role_type   byte_role;
      error_type  error_code;
      logic [1:0] qos_level;
      logic       dup_flag;
      logic       retain_flag;
      logic       last;
   } rsp_item_type;

endpackage

FILE: rtl/mpbp_if.sv
// ----------------------------------------------------------------------------
// MQTT PUBLISH body parser channels
// Valid/ready channels for body bytes in and tagged bytes out.
// ----------------------------------------------------------------------------
interface mpbp_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        first;
   logic [3:0]  header_flags;
   logic [27:0] remaining_length;

   modport source (output valid, output data_byte, output first,
                   output header_flags, output remaining_length, input ready);
   modport sink   (input valid, input data_byte, input first,
                   input header_flags, input remaining_length, output ready);
endinterface

interface mpbp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic [2:0] byte_role;
   logic [2:0] error_code;
   logic [1:0] qos_level;
   logic       dup_flag;
   logic       retain_flag;
   logic       last;

   modport source (output valid, output byte_value, output byte_role,
                   output error_code, output qos_level, output dup_flag,
                   output retain_flag, output last, input ready);
   modport sink   (input valid, input byte_value, input byte_role,
                   input error_code, input qos_level, input dup_flag,
                   input retain_flag, input last, output ready);
endinterface

FILE: rtl/mpbp_core.sv
// ----------------------------------------------------------------------------
// MQTT PUBLISH body parser core
// Packet state registers and the per-beat classification logic.
// ----------------------------------------------------------------------------
module mpbp_core
   import mpbp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  req_item_type item,
   output rsp_item_type result
);

   phase_type                phase_ff, phase_in;
   logic [LenWidth-1:0]      bytes_left_ff, bytes_left_in;
   logic [TopicWidth-1:0]    topic_length_ff, topic_length_in;
   logic [TopicWidth-1:0]    topic_count_ff, topic_count_in;
   logic [1:0]               qos_ff, qos_in;
   logic                     dup_ff, dup_in;
   logic                     retain_ff, retain_in;

   // Packet context as seen by this beat, after a first-beat load.
   phase_type             ph_cur;
   logic [LenWidth-1:0]   left_cur;
   logic [TopicWidth-1:0] tlen_cur;
   logic [TopicWidth-1:0] tcnt_cur;
   logic [TopicWidth-1:0] tcnt_inc;
   logic                  active;
   logic                  last_beat;
   phase_type             next_ph;
   role_type              role;
   error_type             err;

   always_comb begin
      if (item.first) begin
         dup_in    = item.header_flags[3];
         qos_in    = item.header_flags[2:1];
         retain_in = item.header_flags[0];
         left_cur  = item.remaining_length;
         tlen_cur  = '0;
         tcnt_cur  = '0;
         ph_cur    = PH_TLEN_HI;
      end else begin
         dup_in    = dup_ff;
         qos_in    = qos_ff;
         retain_in = retain_ff;
         left_cur  = bytes_left_ff;
         tlen_cur  = topic_length_ff;
         tcnt_cur  = topic_count_ff;
         ph_cur    = phase_ff;
      end

      active   = (ph_cur != PH_IDLE);
      tcnt_inc = tcnt_cur + 1'b1;

      if (left_cur != '0) begin
         bytes_left_in = left_cur - 1'b1;
      end else begin
         bytes_left_in = '0;
      end
      last_beat = active && (bytes_left_in == '0);

      next_ph         = ph_cur;
      role            = ROLE_DISCARD;
      err             = ERR_NONE;
      topic_length_in = tlen_cur;
      topic_count_in  = tcnt_cur;

      unique case (ph_cur)
         PH_IDLE: begin
            next_ph = PH_IDLE;
         end
         PH_TLEN_HI: begin
            role            = ROLE_TLEN;
            topic_length_in = {item.data_byte, 8'h00};
            next_ph         = PH_TLEN_LO;
            if (qos_in == 2'd0 && dup_in) begin
               err = ERR_QOS0_DUP;
            end else if (qos_in == 2'd3) begin
               err = ERR_QOS3;
            end
         end
         PH_TLEN_LO: begin
            role            = ROLE_TLEN;
            topic_length_in = {tlen_cur[15:8], item.data_byte};
            if ({tlen_cur[15:8], item.data_byte} == '0) begin
               err = ERR_EMPTY;
            end else begin
               next_ph = PH_TOPIC;
            end
         end
         PH_TOPIC: begin
            role           = ROLE_TOPIC;
            topic_count_in = tcnt_inc;
            if (tcnt_cur == '0 && item.data_byte == CharDollar) begin
               err = ERR_DOLLAR;
            end else if (item.data_byte == CharHash || item.data_byte == CharPlus) begin
               err = ERR_WILDCARD;
            end
            if (tcnt_inc == tlen_cur) begin
               next_ph = (qos_in == 2'd1 || qos_in == 2'd2) ? PH_PID_HI : PH_PAYLOAD;
            end
         end
         PH_PID_HI: begin
            role    = ROLE_PID;
            next_ph = PH_PID_LO;
         end
         PH_PID_LO: begin
            role    = ROLE_PID;
            next_ph = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            role = ROLE_PAYLOAD;
         end
         PH_DISCARD: begin
            role    = ROLE_DISCARD;
            next_ph = PH_DISCARD;
         end
         default: begin
            role    = ROLE_DISCARD;
            next_ph = PH_DISCARD;
         end
      endcase

      // A packet that ends before its header is complete is an overrun,
      // unless this beat already carries a flag or topic error.
      if (err != ERR_NONE) begin
         next_ph = PH_DISCARD;
      end else if (last_beat && next_ph != PH_PAYLOAD && next_ph != PH_DISCARD) begin
         err     = ERR_OVERRUN;
         next_ph = PH_DISCARD;
      end
      if (last_beat) begin
         next_ph = PH_IDLE;
      end
      phase_in = next_ph;

      result.byte_value  = item.data_byte;
      result.byte_role   = role;
      result.error_code  = err;
      result.qos_level   = qos_in;
      result.dup_flag    = dup_in;
      result.retain_flag = retain_in;
      result.last        = last_beat;
   end

   // A stray beat (no packet open, not a first beat) leaves all state alone.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         bytes_left_ff   <= '0;
         topic_length_ff <= '0;
         topic_count_ff  <= '0;
         qos_ff          <= '0;
         dup_ff          <= 1'b0;
         retain_ff       <= 1'b0;
      end else if (advance && active) begin
         phase_ff        <= phase_in;
         bytes_left_ff   <= bytes_left_in;
         topic_length_ff <= topic_length_in;
         topic_count_ff  <= topic_count_in;
         qos_ff          <= qos_in;
         dup_ff          <= dup_in;
         retain_ff       <= retain_in;
      end
   end

endmodule

FILE: rtl/mqtt_publish_body_parser_unit.sv
// ----------------------------------------------------------------------------
// MQTT PUBLISH body parser unit
// Tags each body byte of a PUBLISH packet with its role and any error.
// ----------------------------------------------------------------------------
// The unit takes one body byte per beat on the req_bus channel and returns
// exactly one tagged beat per input beat on the rsp_bus channel, in order.
// A beat with first set opens a new packet and supplies the fixed-header flag
// nibble and the remaining length; any packet still open is abandoned. Each
// result carries the byte, its role (topic length, topic character, packet
// id, payload or discarded), an error code, the decoded QoS, dup and retain
// flags, and a last marker on the final byte by remaining length. Once an
// error is reported, the rest of that packet comes back as discarded. The
// unit sustains one beat per clock: an input register feeds a single stage
// of compare and counter logic whose result is held in an output register,
// so a beat accepted into the input register reaches rsp_bus from the
// output register once the stage advances, and both registers keep moving
// while the consumer keeps rsp_bus.ready high.
// Back-pressure on rsp_bus stalls the output register, then the input
// register, and finally deasserts req_bus.ready.
module mqtt_publish_body_parser_unit
   import mpbp_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   mpbp_req_if.sink   req_bus,
   mpbp_rsp_if.source rsp_bus
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type core_result;
   logic         advance;
   logic         req_take;

   // The processing stage moves whenever it holds a beat and the output
   // register is empty or being drained in this cycle.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (in_valid_ff && !advance);
      out_valid_in = advance ? 1'b1 : (out_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset; they load only on a transfer.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.data_byte        <= req_bus.data_byte;
         in_item_ff.first            <= req_bus.first;
         in_item_ff.header_flags     <= req_bus.header_flags;
         in_item_ff.remaining_length <= req_bus.remaining_length;
      end
      if (advance) begin
         out_item_ff <= core_result;
      end
   end

   mpbp_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .result  (core_result)
   );

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.byte_value  = out_item_ff.byte_value;
   assign rsp_bus.byte_role   = out_item_ff.byte_role;
   assign rsp_bus.error_code  = out_item_ff.error_code;
   assign rsp_bus.qos_level   = out_item_ff.qos_level;
   assign rsp_bus.dup_flag    = out_item_ff.dup_flag;
   assign rsp_bus.retain_flag = out_item_ff.retain_flag;
   assign rsp_bus.last        = out_item_ff.last;

endmodule

FILE: tb/mpbp_tag_check_pkg.sv
// ----------------------------------------------------------------------------
// PUBLISH body tag scoreboard
// Predicts the tag of each accepted body byte and checks returned beats.
// ----------------------------------------------------------------------------
package mpbp_tag_check_pkg;
   import mpbp_pkg::*;

   class publish_tag_scoreboard;
      phase_type           parse_phase;
      logic [LenWidth-1:0] bytes_left;
      logic [15:0]         topic_length;
      logic [15:0]         topic_count;
      logic [1:0]          qos_held;
      logic                dup_held;
      logic                retain_held;
      rsp_item_type        expected_tags[$];
      int unsigned         checked_beats;
      int unsigned         mismatch_count;

      function new();
         parse_phase    = PH_IDLE;
         bytes_left     = '0;
         topic_length   = '0;
         topic_count    = '0;
         qos_held       = '0;
         dup_held       = 1'b0;
         retain_held    = 1'b0;
         checked_beats  = 0;
         mismatch_count = 0;
      endfunction

      function void report_mismatch(string what);
         $display("MISMATCH beat %0d: %s", checked_beats, what);
         mismatch_count++;
      endfunction

      // Advances the parser state by one accepted byte and queues its tag.
      function void note_byte(req_item_type item);
         rsp_item_type tag;
         phase_type    next_phase;
         tag.byte_value = item.data_byte;
         tag.byte_role  = ROLE_DISCARD;
         tag.error_code = ERR_NONE;
         tag.last       = 1'b0;
         if (item.first) begin
            dup_held     = item.header_flags[3];
            qos_held     = item.header_flags[2:1];
            retain_held  = item.header_flags[0];
            bytes_left   = item.remaining_length;
            topic_length = '0;
            topic_count  = '0;
            parse_phase  = PH_TLEN_HI;
         end
         if (parse_phase != PH_IDLE) begin
            next_phase = parse_phase;
            if (bytes_left != '0) bytes_left = bytes_left - 1'b1;
            tag.last = (bytes_left == '0);
            case (parse_phase)
               PH_TLEN_HI: begin
                  tag.byte_role = ROLE_TLEN;
                  topic_length  = {item.data_byte, 8'h00};
                  next_phase    = PH_TLEN_LO;
                  if (qos_held == 2'd0 && dup_held) tag.error_code = ERR_QOS0_DUP;
                  else if (qos_held == 2'd3) tag.error_code = ERR_QOS3;
               end
               PH_TLEN_LO: begin
                  tag.byte_role = ROLE_TLEN;
                  topic_length  = topic_length | {8'h00, item.data_byte};
                  if (topic_length == '0) tag.error_code = ERR_EMPTY;
                  else next_phase = PH_TOPIC;
               end
               PH_TOPIC: begin
                  tag.byte_role = ROLE_TOPIC;
                  if (topic_count == '0 && item.data_byte == CharDollar)
                     tag.error_code = ERR_DOLLAR;
                  else if (item.data_byte == CharHash || item.data_byte == CharPlus)
                     tag.error_code = ERR_WILDCARD;
                  topic_count = topic_count + 1'b1;
                  if (topic_count == topic_length)
                     next_phase = (qos_held == 2'd1 || qos_held == 2'd2) ? PH_PID_HI : PH_PAYLOAD;
               end
               PH_PID_HI: begin
                  tag.byte_role = ROLE_PID;
                  next_phase    = PH_PID_LO;
               end
               PH_PID_LO: begin
                  tag.byte_role = ROLE_PID;
                  next_phase    = PH_PAYLOAD;
               end
               PH_PAYLOAD: begin
                  tag.byte_role = ROLE_PAYLOAD;
               end
               default: begin
                  tag.byte_role = ROLE_DISCARD;
                  next_phase    = PH_DISCARD;
               end
            endcase
            if (tag.error_code != ERR_NONE) begin
               next_phase = PH_DISCARD;
            end else if (tag.last && next_phase != PH_PAYLOAD && next_phase != PH_DISCARD) begin
               tag.error_code = ERR_OVERRUN;
               next_phase     = PH_DISCARD;
            end
            if (tag.last) next_phase = PH_IDLE;
            parse_phase = next_phase;
         end
         tag.qos_level   = qos_held;
         tag.dup_flag    = dup_held;
         tag.retain_flag = retain_held;
         expected_tags.push_back(tag);
      endfunction

      function void check_tag(rsp_item_type got);
         rsp_item_type want;
         if (expected_tags.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected, byte %02h", got.byte_value));
            checked_beats++;
            return;
         end
         want = expected_tags.pop_front();
         if (got.byte_value !== want.byte_value)
            report_mismatch($sformatf("byte_value %0h, want %0h", got.byte_value, want.byte_value));
         if (got.byte_role !== want.byte_role)
            report_mismatch($sformatf("byte_role %0d, want %0d", got.byte_role, want.byte_role));
         if (got.error_code !== want.error_code)
            report_mismatch($sformatf("error_code %0d, want %0d", got.error_code, want.error_code));
         if (got.qos_level !== want.qos_level)
            report_mismatch($sformatf("qos_level %0d, want %0d", got.qos_level, want.qos_level));
         if (got.dup_flag !== want.dup_flag)
            report_mismatch($sformatf("dup_flag %0b, want %0b", got.dup_flag, want.dup_flag));
         if (got.retain_flag !== want.retain_flag)
            report_mismatch($sformatf("retain_flag %0b, want %0b", got.retain_flag, want.retain_flag));
         if (got.last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
         checked_beats++;
      endfunction
   endclass

endpackage

FILE: tb/tb_mqtt_publish_body_parser_unit.sv
// ----------------------------------------------------------------------------
// PUBLISH body parser unit testbench
// Drives directed and random PUBLISH bodies and checks every tagged beat.
// ----------------------------------------------------------------------------
// A short directed run covers each flag and topic error, the overrun cases,
// a packet of length zero, a stray byte and a restart. A random run then sends
// mostly well-formed packets with random content, mixed with packets that
// carry one fault and with raw noise. Both channels idle in random bursts,
// except for the final stretch, where they stream at full rate.
module tb_mqtt_publish_body_parser_unit;
   import mpbp_pkg::*;
   import mpbp_tag_check_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DirectedItems = 25;
   localparam int unsigned ItemTarget    = DirectedItems + 600;
   // The last beats of the run are sent with no idling on either side.
   localparam int unsigned TailItems     = 100;
   localparam int unsigned StallLimit    = 2000;
   localparam int unsigned SettleCycles  = 10;

   // Kinds of packet that the random run builds.
   typedef enum int unsigned {
      FAULT_NONE,
      FAULT_FLAGS,
      FAULT_EMPTY,
      FAULT_DOLLAR,
      FAULT_WILDCARD,
      FAULT_SHORT,
      FAULT_LONG,
      FAULT_CUT,
      FAULT_NOISE
   } fault_kind_type;

   logic clock;
   logic reset;

   mpbp_req_if req_bus ();
   mpbp_rsp_if rsp_bus ();

   mqtt_publish_body_parser_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   publish_tag_scoreboard tag_board;
   int unsigned           items_sent;
   // One in idle_odds beats starts an idle burst; zero turns idling off.
   int unsigned           idle_odds;
   int unsigned           stall_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Both channels are sampled at the rising edge, before the unit's own
   // registers update, so the monitor sees exactly what was handed over.
   // Inputs are noted first; a result can never share an edge with the
   // input beat that caused it.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            tag_board.note_byte(req_item_type'({req_bus.data_byte, req_bus.first,
                                                req_bus.header_flags,
                                                req_bus.remaining_length}));
         if (rsp_bus.valid && rsp_bus.ready)
            tag_board.check_tag(rsp_item_type'({rsp_bus.byte_value, rsp_bus.byte_role,
                                                rsp_bus.error_code, rsp_bus.qos_level,
                                                rsp_bus.dup_flag, rsp_bus.retain_flag,
                                                rsp_bus.last}));
      end
   end

   // The watchdog ends the run once no beat has moved on either channel for
   // far longer than the worst idle burst plus the pipeline depth.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= StallLimit) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // The consumer holds ready high and drops it for random bursts. Each
   // edge carries at most one update of ready.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   // Presents one beat at a falling edge, possibly after an idle burst, and
   // returns at the rising edge that accepts it. Valid stays high from one
   // beat to the next unless a burst intervenes.
   task automatic send_byte(input logic [7:0] data, input logic first,
                            input logic [3:0] flags, input logic [LenWidth-1:0] len);
      @(negedge clock);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.data_byte        <= data;
      req_bus.first            <= first;
      req_bus.header_flags     <= flags;
      req_bus.remaining_length <= len;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   // A continuation byte. The flag and length fields are don't-care here, so
   // they carry junk that the unit must ignore.
   task automatic send_next(input logic [7:0] data);
      send_byte(data, 1'b0, 4'($urandom_range(0, 15)),
                LenWidth'($urandom_range(0, 32'h0FFF_FFFF)));
   endtask

   // Builds a PUBLISH body with a random topic, packet id and payload, then
   // applies the requested fault and sends the bytes that the fault leaves.
   task automatic send_packet(input fault_kind_type fault);
      logic [7:0]          body[$];
      logic [3:0]          flags;
      logic [LenWidth-1:0] len;
      logic [7:0]          topic_char;
      int unsigned         topic_len;
      int unsigned         tail_bytes;
      int unsigned         head_len;
      int unsigned         send_count;
      flags = 4'($urandom_range(0, 15));
      if (flags[2:1] == 2'd3) flags[2:1] = 2'($urandom_range(0, 2));
      if (flags[2:1] == 2'd0) flags[3] = 1'b0;
      if (fault == FAULT_FLAGS) begin
         if ($urandom_range(0, 1) == 1) begin
            flags[2:1] = 2'd3;
         end else begin
            flags[2:1] = 2'd0;
            flags[3]   = 1'b1;
         end
      end
      topic_len  = (fault == FAULT_EMPTY) ? 0 : $urandom_range(1, 8);
      tail_bytes = $urandom_range(0, 12);
      body.push_back(topic_len[15:8]);
      body.push_back(topic_len[7:0]);
      for (int i = 0; i < topic_len; i++) begin
         topic_char = 8'($urandom_range(0, 255));
         while (topic_char == CharDollar || topic_char == CharHash || topic_char == CharPlus)
            topic_char = 8'($urandom_range(0, 255));
         body.push_back(topic_char);
      end
      if (fault == FAULT_DOLLAR) body[2] = CharDollar;
      if (fault == FAULT_WILDCARD)
         body[2 + $urandom_range(0, topic_len - 1)] = ($urandom_range(0, 1) == 1) ? CharHash
                                                                                 : CharPlus;
      if (flags[2:1] == 2'd1 || flags[2:1] == 2'd2) begin
         body.push_back(8'($urandom_range(0, 255)));
         body.push_back(8'($urandom_range(0, 255)));
      end
      head_len = body.size();
      repeat (tail_bytes) body.push_back(8'($urandom_range(0, 255)));
      len        = LenWidth'(body.size());
      send_count = body.size();
      case (fault)
         FAULT_SHORT: begin
            // The body ends inside the topic length, the topic or the id.
            len        = LenWidth'($urandom_range(1, head_len));
            send_count = 32'(len);
         end
         FAULT_LONG: begin
            // The packet claims more bytes than it gets; the next packet
            // start abandons it.
            len = LenWidth'($urandom_range(0, 32'h0FFF_FFFF));
            if (len <= send_count) len = LenWidth'(send_count + $urandom_range(1, 500));
         end
         FAULT_CUT: begin
            send_count = $urandom_range(1, body.size());
         end
         default: begin
         end
      endcase
      for (int i = 0; i < send_count; i++) begin
         if (i == 0) send_byte(body[0], 1'b1, flags, len);
         else send_next(body[i]);
      end
   endtask

   initial begin
      fault_kind_type fault;
      tag_board                = new();
      items_sent               = 0;
      idle_odds                = 4;
      stall_cycles             = 0;
      reset                    = 1'b1;
      req_bus.valid            = 1'b0;
      req_bus.data_byte        = '0;
      req_bus.first            = 1'b0;
      req_bus.header_flags     = '0;
      req_bus.remaining_length = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A stray byte with no packet open is discarded with the reset flags.
      send_next(8'hA5);
      // A packet of length zero is its own last byte and overruns at once.
      send_byte(8'h00, 1'b1, 4'b0011, 28'd0);
      // QoS 0 with dup fails on its first byte; a QoS 3 start with the
      // largest length abandons it and fails in turn.
      send_byte(8'h00, 1'b1, 4'b1000, 28'd5);
      send_byte(8'hFF, 1'b1, 4'b0110, 28'hFFF_FFFF);
      // An empty topic fails on the low length byte; the rest is discarded.
      send_byte(8'h00, 1'b1, 4'b0001, 28'd3);
      send_next(8'h00);
      send_next(8'h55);
      // A dollar as the first topic character, then a discarded hash.
      send_byte(8'h00, 1'b1, 4'b0010, 28'd4);
      send_next(8'h02);
      send_next(CharDollar);
      send_next(CharHash);
      // A plus on the final byte: the wildcard wins over the overrun.
      send_byte(8'h00, 1'b1, 4'b1101, 28'd4);
      send_next(8'h02);
      send_next(8'h61);
      send_next(CharPlus);
      // The body ends on the first packet id byte of a QoS 2 packet.
      send_byte(8'h00, 1'b1, 4'b0100, 28'd4);
      send_next(8'h01);
      send_next(8'h78);
      send_next(8'h12);
      // A clean QoS 1 packet with dup and retain and one payload byte.
      send_byte(8'h00, 1'b1, 4'b1011, 28'd6);
      send_next(8'h01);
      send_next(8'h2F);
      send_next(8'hAB);
      send_next(8'hCD);
      send_next(8'hFF);

      // Mostly clean packets; seven in sixteen carry a fault or are noise.
      while (items_sent < ItemTarget) begin
         if (items_sent + TailItems >= ItemTarget) begin
            idle_odds = 0;
         end else if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
               0: idle_odds = 0;
               1: idle_odds = 2;
               2: idle_odds = 6;
               default: idle_odds = 20;
            endcase
         end
         case ($urandom_range(0, 15))
            9:  fault = FAULT_FLAGS;
            10: fault = FAULT_EMPTY;
            11: fault = FAULT_DOLLAR;
            12: fault = FAULT_WILDCARD;
            13: fault = FAULT_SHORT;
            14: fault = ($urandom_range(0, 1) == 1) ? FAULT_LONG : FAULT_CUT;
            15: fault = FAULT_NOISE;
            default: fault = FAULT_NONE;
         endcase
         if (fault == FAULT_NOISE) begin
            // Raw bytes: mostly strays, now and then a start with random
            // flags and a length anywhere in the field's range.
            repeat ($urandom_range(1, 4))
               send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0),
                         4'($urandom_range(0, 15)),
                         LenWidth'($urandom_range(0, 32'h0FFF_FFFF)));
         end else begin
            send_packet(fault);
         end
      end

      // Lower valid at the next falling edge; by then the monitor has noted
      // the last beat, so the queue of expected tags is complete.
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (tag_board.expected_tags.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      if (tag_board.mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/mpbp_pkg.sv
rtl/mpbp_if.sv
rtl/mpbp_core.sv
rtl/mqtt_publish_body_parser_unit.sv
tb/mpbp_tag_check_pkg.sv
tb/tb_mqtt_publish_body_parser_unit.sv
